### sv/swk_pkg.sv
// ----------------------------------------------------------------------------
// swk_pkg - shared types and constants for the swerve wheel kinematics block
// Widths of the datapath, register indexes, sequencer states and the
// arctangent table used by the CORDIC unit.
// ----------------------------------------------------------------------------
package swk_pkg;

    // stream payload widths
    localparam int IN_FIELD_W  = 16;
    localparam int IN_TDATA_W  = 48;   // three 16 bit fields
    localparam int OUT_TDATA_W = 40;   // 18 + 16 bits, padded to whole bytes
    localparam int IDX_W       = 3;    // wheel_index
    localparam int SPEED_W     = 18;
    localparam int ANGLE_W     = 16;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_W      = 10;

    localparam logic [CFG_ADDR_W-1:0] CFG_FRONT_AXLE_X      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIDDLE_AXLE_X     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REAR_AXLE_X       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRONT_HALF_TRACK  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIDDLE_HALF_TRACK = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_REAR_HALF_TRACK   = 3'd5;

    // datapath widths
    localparam int V_W     = 19;   // wheel velocity components, signed Q.8
    localparam int PROD_W  = 38;   // shared multiplier result
    localparam int SQ_W    = 36;   // sum of squares, unsigned
    localparam int SQ_ITER = 18;   // one root bit per iteration
    localparam int SQ_CNT_W = 5;
    localparam int C_W     = 21;   // CORDIC x and y
    localparam int Z_W     = 24;   // CORDIC angle, signed Q.20
    localparam int TAB_W   = 5;    // arctangent table index

    localparam logic signed [Z_W-1:0]  HALF_PI_Q20 = 24'sd1647099;
    localparam logic signed [Z_W-1:0]  ROUND_Q7    = 24'sd64;
    localparam logic signed [16:0]     ANGLE_LIM   = 17'sd25736;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_PY,
        ST_MUL_PX,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SUM,
        ST_RUN,
        ST_OUT
    } t_swk_state;

    // arctangent of 2^-i in Q.20, rounded
    function automatic logic signed [Z_W-1:0] atan_q20(input logic [TAB_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = 24'sd823550;
            5'd1:    v = 24'sd486170;
            5'd2:    v = 24'sd256879;
            5'd3:    v = 24'sd130396;
            5'd4:    v = 24'sd65451;
            5'd5:    v = 24'sd32757;
            5'd6:    v = 24'sd16383;
            5'd7:    v = 24'sd8192;
            5'd8:    v = 24'sd4096;
            5'd9:    v = 24'sd2048;
            5'd10:   v = 24'sd1024;
            5'd11:   v = 24'sd512;
            5'd12:   v = 24'sd256;
            5'd13:   v = 24'sd128;
            5'd14:   v = 24'sd64;
            5'd15:   v = 24'sd32;
            5'd16:   v = 24'sd16;
            5'd17:   v = 24'sd8;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            5'd20:   v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

endpackage

### sv/swk_sqrt.sv
// ----------------------------------------------------------------------------
// swk_sqrt - iterative integer square root
// Digit-by-digit root of a 36 bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
module swk_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [swk_pkg::SQ_W-1:0]  i_radicand,
    output logic                      o_busy,
    output logic [swk_pkg::SPEED_W-1:0] o_root
);
    import swk_pkg::*;

    logic [SQ_W-1:0]     r_n, n_n;
    logic [SQ_W-1:0]     r_r, n_r;
    logic [SQ_W-1:0]     r_bit, n_bit;
    logic [SQ_CNT_W-1:0] r_cnt, n_cnt;
    logic                r_busy, n_busy;
    logic [SQ_W-1:0]     trial;

    // compare the remainder against root plus current bit
    always_comb begin
        trial  = r_r + r_bit;
        n_n    = r_n;
        n_r    = r_r;
        n_bit  = r_bit;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_n    = i_radicand;
            n_r    = '0;
            n_bit  = SQ_W'(1) << (SQ_W - 2);
            n_cnt  = SQ_CNT_W'(SQ_ITER - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_n >= trial) begin
                n_n = r_n - trial;
                n_r = (r_r >> 1) + r_bit;
            end else begin
                n_r = r_r >> 1;
            end
            n_bit = r_bit >> 2;
            n_cnt = r_cnt - SQ_CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    // hold busy under reset, datapath free-running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_n   <= n_n;
        r_r   <= n_r;
        r_bit <= n_bit;
        r_cnt <= n_cnt;
    end

    assign o_busy = r_busy;
    // the root of a 36 bit value never exceeds 18 bits, so no saturation occurs
    assign o_root = r_r[SPEED_W-1:0];

endmodule

### sv/swk_cordic.sv
// ----------------------------------------------------------------------------
// swk_cordic - iterative vectoring CORDIC for atan2
// Pre-rotates the left half plane by a quarter turn, then runs one
// shift-add micro-rotation per cycle and rounds the angle to Q3.13.
// ----------------------------------------------------------------------------
module swk_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [swk_pkg::V_W-1:0]    i_vx,
    input  logic signed [swk_pkg::V_W-1:0]    i_vy,
    output logic                              o_busy,
    output logic signed [swk_pkg::ANGLE_W-1:0] o_angle
);
    import swk_pkg::*;

    localparam int STEP_W = $clog2(CORDIC_STEPS);

    logic signed [C_W-1:0] r_x, n_x;
    logic signed [C_W-1:0] r_y, n_y;
    logic signed [Z_W-1:0] r_z, n_z;
    logic [STEP_W-1:0]     r_step, n_step;
    logic                  r_busy, n_busy;
    logic                  r_zero, n_zero;

    logic signed [C_W-1:0] vx_ext, vy_ext;
    logic signed [C_W-1:0] xs, ys;
    logic                  y_pos;
    logic signed [Z_W-1:0] z_rnd;
    logic signed [16:0]    z_q13;
    logic signed [16:0]    z_clamp;

    assign vx_ext = C_W'(i_vx);
    assign vy_ext = C_W'(i_vy);
    assign xs     = r_x >>> r_step;
    assign ys     = r_y >>> r_step;
    assign y_pos  = !r_y[C_W-1] && (r_y != '0);

    // load with quarter-turn pre-rotation, then rotate toward the x axis
    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        n_step = r_step;
        n_busy = r_busy;
        n_zero = r_zero;
        if (i_start) begin
            n_step = '0;
            n_busy = 1'b1;
            n_zero = (i_vx == '0) && (i_vy == '0);
            if (i_vx[V_W-1]) begin
                if (!i_vy[V_W-1]) begin
                    n_x = vy_ext;
                    n_y = -vx_ext;
                    n_z = HALF_PI_Q20;
                end else begin
                    n_x = -vy_ext;
                    n_y = vx_ext;
                    n_z = -HALF_PI_Q20;
                end
            end else begin
                n_x = vx_ext;
                n_y = vy_ext;
                n_z = '0;
            end
        end else if (r_busy) begin
            if (y_pos) begin
                n_x = r_x + ys;
                n_y = r_y - xs;
                n_z = r_z + atan_q20(TAB_W'(r_step));
            end else begin
                n_x = r_x - ys;
                n_y = r_y + xs;
                n_z = r_z - atan_q20(TAB_W'(r_step));
            end
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_step <= n_step;
        r_zero <= n_zero;
    end

    // round half up to Q.13 and clamp to plus or minus pi
    always_comb begin
        z_rnd = r_z + ROUND_Q7;
        z_q13 = z_rnd[Z_W-1:7];
        if (z_q13 > ANGLE_LIM) begin
            z_clamp = ANGLE_LIM;
        end else if (z_q13 < -ANGLE_LIM) begin
            z_clamp = -ANGLE_LIM;
        end else begin
            z_clamp = z_q13;
        end
    end

    assign o_busy  = r_busy;
    assign o_angle = r_zero ? '0 : z_clamp[ANGLE_W-1:0];

endmodule

### sv/swerve_wheel_kinematics.sv
// Sequence: per wheel, the shared multiplier and load states (MUL_PY, MUL_PX, SQ_X, SQ_Y,
// SUM), then root and CORDIC in parallel, then the load of the output register.
// A new command is taken only after the last wheel's result is loaded, paced by the
// shared multiplier and the iterative units; a held result register stalls the sequencer.
// Reset: synchronous active low; clears sequencer and handshakes, loads geometry reset values.
// ----------------------------------------------------------------------------
// swerve_wheel_kinematics - inverse kinematics for a swerve drive
// Turns one body velocity command into a speed and steering angle per
// wheel, using one shared multiplier, an iterative root and a CORDIC.
// ----------------------------------------------------------------------------
module swerve_wheel_kinematics #(
    parameter int NUM_WHEELS   = 6,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [swk_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [swk_pkg::CFG_W-1:0]           i_cfg_wdata,
    // command stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [15:0] linear_x, [31:16] linear_y, [47:32] angular_z
    input  logic [swk_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // wheel result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [17:0] wheel_speed, [33:18] heading, [39:34] zero
    output logic [swk_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // [2:0] wheel_index
    output logic [swk_pkg::IDX_W-1:0]           o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);
    import swk_pkg::*;

    localparam int WHL_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

    t_swk_state r_state, n_state;

    // geometry registers
    logic signed [CFG_W-1:0] r_front_x, r_middle_x, r_rear_x;
    logic signed [CFG_W-1:0] r_front_t, r_middle_t, r_rear_t;

    // command and per-wheel datapath
    logic signed [IN_FIELD_W-1:0] r_lx, r_ly, r_wz;
    logic [WHL_W-1:0]             r_wheel, n_wheel;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [V_W-1:0]        r_vx, r_vy;
    logic [SQ_W-1:0]              r_acc;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic [SPEED_W-1:0]           r_out_speed;
    logic signed [ANGLE_W-1:0]    r_out_angle;
    logic [IDX_W-1:0]             r_out_wheel;
    logic                         r_out_last;

    logic [WHL_W-1:0]             pair_idx;
    logic signed [CFG_W-1:0]      px_sel, pt_sel;
    logic signed [CFG_W:0]        py_sel;
    logic signed [V_W-1:0]        mul_a, mul_b;
    logic signed [PROD_W-1:0]     mul_p;
    logic                         in_fire, out_slot_free, load_out, wheel_last;
    logic                         sqrt_start, sqrt_busy, cordic_busy;
    logic [SQ_W-1:0]              sum_sq;
    logic [SPEED_W-1:0]           root;
    logic signed [ANGLE_W-1:0]    angle;

    assign in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_slot_free = !r_out_valid || i_m_axis_tready;
    assign wheel_last    = (r_wheel == WHL_W'(NUM_WHEELS - 1));

    // pick the wheel position: front, middle, then rear for every later pair
    always_comb begin
        pair_idx = r_wheel >> 1;
        if (pair_idx == '0) begin
            px_sel = r_front_x;
            pt_sel = r_front_t;
        end else if (pair_idx == WHL_W'(1)) begin
            px_sel = r_middle_x;
            pt_sel = r_middle_t;
        end else begin
            px_sel = r_rear_x;
            pt_sel = r_rear_t;
        end
        // right wheels take the negated half track
        if (r_wheel[0]) begin
            py_sel = -(CFG_W + 1)'(pt_sel);
        end else begin
            py_sel = (CFG_W + 1)'(pt_sel);
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            ST_MUL_PY: begin
                mul_a = V_W'(py_sel);
                mul_b = V_W'(r_wz);
            end
            ST_MUL_PX: begin
                mul_a = V_W'(px_sel);
                mul_b = V_W'(r_wz);
            end
            ST_SQ_X: begin
                mul_a = r_vx;
                mul_b = r_vx;
            end
            ST_SQ_Y: begin
                mul_a = r_vy;
                mul_b = r_vy;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign sum_sq = r_acc + r_prod[SQ_W-1:0];

    // sequencer: next state and strobes
    always_comb begin
        n_state     = r_state;
        n_wheel     = r_wheel;
        n_out_valid = r_out_valid;
        sqrt_start  = 1'b0;
        load_out    = 1'b0;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_wheel = '0;
                    n_state = ST_MUL_PY;
                end
            end
            ST_MUL_PY: n_state = ST_MUL_PX;
            ST_MUL_PX: n_state = ST_SQ_X;
            ST_SQ_X:   n_state = ST_SQ_Y;
            ST_SQ_Y:   n_state = ST_SUM;
            ST_SUM: begin
                sqrt_start = 1'b1;
                n_state    = ST_RUN;
            end
            ST_RUN: begin
                if (!sqrt_busy && !cordic_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_slot_free) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    if (wheel_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_wheel = r_wheel + WHL_W'(1);
                        n_state = ST_MUL_PY;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state and handshake registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_wheel     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_wheel     <= n_wheel;
        end
    end

    // geometry register writes; out of range indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_x  <= 10'sd128;
            r_middle_x <= 10'sd0;
            r_rear_x   <= -10'sd128;
            r_front_t  <= 10'sd128;
            r_middle_t <= 10'sd0;
            r_rear_t   <= 10'sd128;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_FRONT_AXLE_X:      r_front_x  <= i_cfg_wdata;
                CFG_MIDDLE_AXLE_X:     r_middle_x <= i_cfg_wdata;
                CFG_REAR_AXLE_X:       r_rear_x   <= i_cfg_wdata;
                CFG_FRONT_HALF_TRACK:  r_front_t  <= i_cfg_wdata;
                CFG_MIDDLE_HALF_TRACK: r_middle_t <= i_cfg_wdata;
                CFG_REAR_HALF_TRACK:   r_rear_t   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // datapath: capture the command, products, wheel velocity, x square and output result
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_lx <= i_s_axis_tdata[15:0];
            r_ly <= i_s_axis_tdata[31:16];
            r_wz <= i_s_axis_tdata[47:32];
        end
        r_prod <= mul_p;
        // floor of each product to Q.8 is the bit slice above the fraction
        if (r_state == ST_MUL_PX) begin
            r_vx <= V_W'(r_lx) - r_prod[V_W+7:8];
        end
        if (r_state == ST_SQ_X) begin
            r_vy <= V_W'(r_ly) + r_prod[V_W+7:8];
        end
        if (r_state == ST_SQ_Y) begin
            r_acc <= r_prod[SQ_W-1:0];
        end
        if (load_out) begin
            r_out_speed <= root;
            r_out_angle <= angle;
            r_out_wheel <= IDX_W'(r_wheel);
            r_out_last  <= wheel_last;
        end
    end

    swk_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (sum_sq),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

    swk_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_vx    (r_vx),
        .i_vy    (r_vy),
        .o_busy  (cordic_busy),
        .o_angle (angle)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - SPEED_W - ANGLE_W){1'b0}}, r_out_angle,
                              r_out_speed};
    assign o_m_axis_tuser  = r_out_wheel;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_s_axis_tready)
        else $error("block still ready after taking a command");

    a_units_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (!sqrt_busy && !cordic_busy))
        else $error("root or CORDIC unit busy while waiting for a command");

    a_last_on_final_wheel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (o_m_axis_tuser == IDX_W'(NUM_WHEELS - 1)))
        else $error("last flag on a wheel other than the final one");

    a_wheel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser <= IDX_W'(NUM_WHEELS - 1)))
        else $error("wheel index beyond the wheel count");
`endif

endmodule
